### hdl/sds_pkg.sv
// Package for the shared dual stack: sizes, command codes and the
// control and status types passed between controller and datapath.
// No dependencies.
package sds_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_TOP  = 2'd2;

    localparam logic SEL_LOW  = 1'b0;
    localparam logic SEL_HIGH = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic take;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

### hdl/sds_if.sv
// Request and response channel interfaces of the shared dual stack.
// No dependencies.
interface sds_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        stack_sel;
    logic [31:0] push_value;

    modport source (output valid, cmd, stack_sel, push_value, input ready);
    modport sink (input valid, cmd, stack_sel, push_value, output ready);
endinterface

interface sds_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] top_value;
    logic        full_res;
    logic        empty_low;
    logic        empty_high;

    modport source (output valid, ok, top_value, full_res, empty_low, empty_high,
                    input ready);
    modport sink (input valid, ok, top_value, full_res, empty_low, empty_high,
                  output ready);
endinterface

### hdl/sds_ctrl.sv
// Controller of the shared dual stack: a two-state machine that takes a
// request and then lets the datapath finish it. Depends on sds_pkg.
module sds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  sds_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output sds_pkg::t_ctl_cmd o_cmd
);
    import sds_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.take   = 1'b0;
        o_cmd.finish = 1'b0;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.out_busy || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/sds_dp.sv
// Datapath of the shared dual stack: the shared memory, both stack counts
// and the result register. Depends on sds_pkg.
module sds_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sds_pkg::t_ctl_cmd i_cmd,
    input  logic [1:0]        i_op,
    input  logic              i_stack_sel,
    input  logic [31:0]       i_push_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_ok,
    output logic [31:0]       o_top_value,
    output logic              o_full_res,
    output logic              o_empty_low,
    output logic              o_empty_high,
    output sds_pkg::t_dp_stat o_stat
);
    import sds_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [CW-1:0]         r_low_count;
    logic [CW-1:0]         r_high_count;
    logic [CW-1:0]         n_low_count;
    logic [CW-1:0]         n_high_count;
    logic                  r_ok_pend;
    logic                  r_is_read;
    logic                  r_out_valid;
    logic                  r_ok;
    logic [31:0]           r_top;
    logic                  r_full;
    logic                  r_empty_low;
    logic                  r_empty_high;

    logic [CW:0]   w_sum;
    logic          w_full;
    logic          w_low_nz;
    logic          w_high_nz;
    logic          w_ok;
    logic          w_we;
    logic          w_re;
    logic [CW-1:0] w_addr_full;
    logic [AW-1:0] w_addr;
    logic [CW:0]   w_sum_next;

    assign w_sum     = {1'b0, r_low_count} + {1'b0, r_high_count};
    assign w_full    = w_sum >= (CW + 1)'(DEPTH);
    assign w_low_nz  = r_low_count != '0;
    assign w_high_nz = r_high_count != '0;

    always_comb begin
        w_ok         = 1'b0;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_addr_full  = '0;
        n_low_count  = r_low_count;
        n_high_count = r_high_count;
        case (i_op)
            CMD_PUSH: begin
                if (!w_full) begin
                    w_ok = 1'b1;
                    w_we = i_cmd.take;
                    if (i_stack_sel == SEL_LOW) begin
                        w_addr_full = r_low_count;
                        n_low_count = r_low_count + 1'b1;
                    end else begin
                        w_addr_full  = CW'(DEPTH - 1) - r_high_count;
                        n_high_count = r_high_count + 1'b1;
                    end
                end
            end
            CMD_POP: begin
                if (i_stack_sel == SEL_LOW && w_low_nz) begin
                    w_ok        = 1'b1;
                    n_low_count = r_low_count - 1'b1;
                end else if (i_stack_sel == SEL_HIGH && w_high_nz) begin
                    w_ok         = 1'b1;
                    n_high_count = r_high_count - 1'b1;
                end
            end
            CMD_TOP: begin
                if (i_stack_sel == SEL_LOW && w_low_nz) begin
                    w_ok        = 1'b1;
                    w_re        = i_cmd.take;
                    w_addr_full = r_low_count - 1'b1;
                end else if (i_stack_sel == SEL_HIGH && w_high_nz) begin
                    w_ok        = 1'b1;
                    w_re        = i_cmd.take;
                    w_addr_full = CW'(DEPTH) - r_high_count;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign w_addr = w_addr_full[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= i_push_value[DATA_WIDTH-1:0];
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_count  <= '0;
            r_high_count <= '0;
        end else if (i_cmd.take) begin
            r_low_count  <= n_low_count;
            r_high_count <= n_high_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ok_pend <= w_ok;
            r_is_read <= i_op == CMD_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ok         <= r_ok_pend;
            r_top        <= (r_ok_pend && r_is_read) ? 32'(r_rd_data) : '0;
            r_full       <= w_full;
            r_empty_low  <= !w_low_nz;
            r_empty_high <= !w_high_nz;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_top_value     = r_top;
    assign o_full_res      = r_full;
    assign o_empty_low     = r_empty_low;
    assign o_empty_high    = r_empty_high;
    assign o_stat.out_busy = r_out_valid;

    assign w_sum_next = {1'b0, n_low_count} + {1'b0, n_high_count};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum <= (CW + 1)'(DEPTH))
        else $error("stack counts exceed the memory depth");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_out_valid)
        else $error("finished request did not raise the result valid");

    a_take_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> w_sum_next <= (CW + 1)'(DEPTH))
        else $error("request would overfill the shared memory");

    a_top_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_top_value != '0) |-> o_ok)
        else $error("nonzero top value on a failed result");

endmodule

### hdl/shared_dual_stack.sv
// Top level of the shared dual stack: joins the controller and the datapath
// to the request and response channels. Depends on sds_pkg, sds_if, sds_ctrl
// and sds_dp.
//
// Two stacks share one memory of sds_pkg::DEPTH words: the low stack grows
// upward from entry zero and the high stack grows downward from the last
// entry. Each request transfer pushes, pops or reads the top of one stack and
// gives exactly one response transfer with a success flag, the top value on
// a successful top read, and the full and empty flags after the step. A
// request first updates the counts and accesses the memory as it is taken in
// S_IDLE; then, in S_EXEC, the registered memory read reaches the response
// register. The next request is taken while a response waits, so long as
// that response leaves the register at the same edge; no request is taken
// while the controller is in S_EXEC.
module shared_dual_stack (
    input logic    i_clk,
    input logic    i_rst_n,
    sds_req_if.sink   i_req,
    sds_rsp_if.source o_rsp
);
    import sds_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    sds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_req.ready),
        .o_cmd       (w_cmd)
    );

    sds_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (i_req.cmd),
        .i_stack_sel  (i_req.stack_sel),
        .i_push_value (i_req.push_value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_ok         (o_rsp.ok),
        .o_top_value  (o_rsp.top_value),
        .o_full_res   (o_rsp.full_res),
        .o_empty_low  (o_rsp.empty_low),
        .o_empty_high (o_rsp.empty_high),
        .o_stat       (w_stat)
    );

endmodule

### test/shared_dual_stack_tb.sv
// Self-checking testbench for shared_dual_stack: a directed table followed by random
// push, pop, top-read and unused-command traffic; every response is checked against a
// row's want or a local model. Depends on sds_pkg, sds_if and the shared_dual_stack RTL.
`timescale 1ns / 1ps

module shared_dual_stack_tb;

    import sds_pkg::*;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         N_RANDOM   = 1550;
    localparam int         IDLE_PCT   = 16;
    localparam int         REPORT_MAX = 10;

    typedef struct packed {
        logic                  ok;
        logic [31:0]           top_value;
        logic                  full_res;
        logic                  empty_low;
        logic                  empty_high;
    } t_stack_rsp;

    typedef struct {
        logic [1:0]  cmd;
        logic        sel;
        logic [31:0] val;
        int          reps;
        bit          has_want;
        t_stack_rsp  want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    sds_req_if req_ch();
    sds_rsp_if rsp_ch();

    shared_dual_stack u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [DATA_WIDTH-1:0] stack_mem [DEPTH];
    int                    low_used;
    int                    high_used;
    t_stack_rsp            pending_rsp [$];
    bit                    cur_has_want;
    t_stack_rsp            cur_want;
    bit                    steady;
    int                    n_errors;
    int                    n_reported;
    int                    n_ok;
    int                    n_failed;
    int                    n_full;
    int                    n_spare;

    t_script_row script [26] = '{
        '{CMD_TOP,   SEL_LOW,  32'h0,         1,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{CMD_TOP,   SEL_HIGH, 32'h0,         1,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{CMD_POP,   SEL_LOW,  32'h0,         1,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{CMD_POP,   SEL_HIGH, 32'h0,         1,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{CMD_SPARE, SEL_LOW,  32'hFFFF_FFFF, 1,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{CMD_PUSH,  SEL_LOW,  32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b1}},
        '{CMD_PUSH,  SEL_LOW,  32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b1}},
        '{CMD_TOP,   SEL_LOW,  32'h0,         1,  1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}},
        '{CMD_PUSH,  SEL_HIGH, 32'hFFFF_FFFF, 1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_PUSH,  SEL_HIGH, 32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_TOP,   SEL_HIGH, 32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_POP,   SEL_HIGH, 32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_TOP,   SEL_HIGH, 32'h0,         1,  1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
        '{CMD_SPARE, SEL_HIGH, 32'h0,         1,  1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_POP,   SEL_LOW,  32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_TOP,   SEL_LOW,  32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_POP,   SEL_LOW,  32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b1, 1'b0}},
        '{CMD_POP,   SEL_HIGH, 32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{CMD_PUSH,  SEL_LOW,  32'h1000_0000, 60, 1'b0, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_PUSH,  SEL_HIGH, 32'h2000_0000, 68, 1'b0, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_PUSH,  SEL_LOW,  32'h5555_5555, 1,  1'b1, '{1'b0, 32'h0, 1'b1, 1'b0, 1'b0}},
        '{CMD_PUSH,  SEL_HIGH, 32'hAAAA_AAAA, 1,  1'b1, '{1'b0, 32'h0, 1'b1, 1'b0, 1'b0}},
        '{CMD_TOP,   SEL_LOW,  32'h0,         1,  1'b0, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_TOP,   SEL_HIGH, 32'h0,         1,  1'b0, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0}},
        '{CMD_SPARE, SEL_HIGH, 32'h0,         1,  1'b1, '{1'b0, 32'h0, 1'b1, 1'b0, 1'b0}},
        '{CMD_POP,   SEL_HIGH, 32'h0,         1,  1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0}}
    };

    function automatic t_stack_rsp step_stacks(input logic [1:0] cmd, input logic sel,
                                               input logic [31:0] val);
        t_stack_rsp r;
        r = '0;
        case (cmd)
            CMD_PUSH: begin
                if (low_used + high_used < DEPTH) begin
                    if (sel == SEL_LOW) begin
                        stack_mem[low_used] = val[DATA_WIDTH-1:0];
                        low_used++;
                    end else begin
                        high_used++;
                        stack_mem[DEPTH - high_used] = val[DATA_WIDTH-1:0];
                    end
                    r.ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (sel == SEL_LOW && low_used > 0) begin
                    low_used--;
                    r.ok = 1'b1;
                end else if (sel == SEL_HIGH && high_used > 0) begin
                    high_used--;
                    r.ok = 1'b1;
                end
            end
            CMD_TOP: begin
                if (sel == SEL_LOW && low_used > 0) begin
                    r.top_value = stack_mem[low_used - 1];
                    r.ok        = 1'b1;
                end else if (sel == SEL_HIGH && high_used > 0) begin
                    r.top_value = stack_mem[DEPTH - high_used];
                    r.ok        = 1'b1;
                end
            end
            default: ;
        endcase
        r.full_res   = (low_used + high_used >= DEPTH);
        r.empty_low  = (low_used == 0);
        r.empty_high = (high_used == 0);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic sel, input logic [31:0] val,
                             input bit has_want, input t_stack_rsp want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.cmd        = cmd;
        req_ch.stack_sel  = sel;
        req_ch.push_value = val;
        cur_has_want      = has_want;
        cur_want          = want;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d responses still outstanding.", pending_rsp.size());
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        rsp_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_stack_rsp got;
        t_stack_rsp model;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.ok, rsp_ch.top_value, rsp_ch.full_res, rsp_ch.empty_low,
                        rsp_ch.empty_high};
                if (pending_rsp.size() == 0) begin
                    n_errors++;
                    if (n_reported < REPORT_MAX) begin
                        n_reported++;
                        $display("%t: response transfer with none outstanding: %p", $realtime,
                                 got);
                    end
                end else begin
                    model = pending_rsp.pop_front();
                    if (got.ok !== model.ok || got.top_value !== model.top_value ||
                        got.full_res !== model.full_res || got.empty_low !== model.empty_low ||
                        got.empty_high !== model.empty_high) begin
                        n_errors++;
                        if (n_reported < REPORT_MAX) begin
                            n_reported++;
                            $display("%t: mismatch ok %b/%b top %h/%h full %b/%b el %b/%b eh %b/%b",
                                     $realtime, model.ok, got.ok, model.top_value,
                                     got.top_value, model.full_res, got.full_res,
                                     model.empty_low, got.empty_low, model.empty_high,
                                     got.empty_high);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                model = step_stacks(req_ch.cmd, req_ch.stack_sel, req_ch.push_value);
                if (cur_has_want) begin
                    model = cur_want;
                end
                if (req_ch.cmd == CMD_SPARE) begin
                    n_spare++;
                end else if (model.ok) begin
                    n_ok++;
                end else begin
                    n_failed++;
                end
                if (model.full_res) begin
                    n_full++;
                end
                pending_rsp.push_back(model);
            end
        end
    end

    initial begin
        int          burst_left;
        int          mode;
        int          pick;
        int          waited;
        logic [1:0]  cmd;
        logic [31:0] val;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_PUSH;
        req_ch.stack_sel  = SEL_LOW;
        req_ch.push_value = '0;
        cur_has_want      = 1'b0;
        cur_want          = '0;
        steady            = 1'b0;
        low_used          = 0;
        high_used         = 0;
        n_errors          = 0;
        n_reported        = 0;
        n_ok              = 0;
        n_failed          = 0;
        n_full            = 0;
        n_spare           = 0;
        burst_left        = 0;
        mode              = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                send_item(script[r].cmd, script[r].sel, script[r].val + k, script[r].has_want,
                          script[r].want);
            end
        end
        wait_drained();

        // Bursts lean toward filling or draining so that both the full and the empty
        // boundaries are crossed many times; the third kind is an even mix.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (burst_left == 0) begin
                mode       = $urandom_range(2);
                burst_left = $urandom_range(40, 200);
            end
            burst_left--;
            steady = (i >= 700 && i < 1000);
            if (i == 1200) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            case (mode)
                0: cmd = (pick < 80) ? CMD_PUSH : (pick < 90) ? CMD_TOP :
                         (pick < 97) ? CMD_POP : CMD_SPARE;
                1: cmd = (pick < 15) ? CMD_PUSH : (pick < 60) ? CMD_POP :
                         (pick < 97) ? CMD_TOP : CMD_SPARE;
                default: cmd = (pick < 35) ? CMD_PUSH : (pick < 65) ? CMD_POP :
                               (pick < 93) ? CMD_TOP : CMD_SPARE;
            endcase
            pick = $urandom_range(9);
            val  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            send_item(cmd, 1'($urandom_range(1)), val, 1'b0, '0);
        end
        steady       = 1'b0;
        req_ch.valid = 1'b0;

        waited = 0;
        while (pending_rsp.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_rsp.size() != 0) begin
            n_errors += pending_rsp.size();
            $display("%0d responses never arrived.", pending_rsp.size());
        end
        repeat (8) @(negedge i_clk);

        $display("Covered %0d successful and %0d refused operations plus %0d unused commands,",
                 n_ok, n_failed, n_spare);
        $display("with the shared memory full after %0d of them; %0d mismatches.", n_full,
                 n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### shared_dual_stack.f
hdl/sds_pkg.sv
hdl/sds_if.sv
hdl/sds_ctrl.sv
hdl/sds_dp.sv
hdl/shared_dual_stack.sv
test/shared_dual_stack_tb.sv
